[sv/mwc_pkg.sv]
package mwc_pkg;
  localparam logic [31:0] SEED_W_RESET = 32'd521288629;
  localparam logic [31:0] SEED_Z_RESET = 32'd362436069;
  localparam int MAX_TRIES = 32;

  localparam logic [3:0] OP_R32     = 4'd0;
  localparam logic [3:0] OP_R64     = 4'd1;
  localparam logic [3:0] OP_R16     = 4'd2;
  localparam logic [3:0] OP_R8      = 4'd3;
  localparam logic [3:0] OP_R1      = 4'd4;
  localparam logic [3:0] OP_MOD8    = 4'd5;
  localparam logic [3:0] OP_MOD16   = 4'd6;
  localparam logic [3:0] OP_MOD32   = 4'd7;
  localparam logic [3:0] OP_MOD32P2 = 4'd8;
  localparam logic [3:0] OP_MOD64   = 4'd9;

  localparam logic REG_SEED_W = 1'b0;
  localparam logic REG_SEED_Z = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DRAW, ST_DRAW2, ST_SHIFT, ST_CHECK, ST_DIV, ST_DONE
  } state_t;
endpackage

[sv/mwc_divider.sv]
// Restoring divider, one quotient bit per cycle; only the remainder is kept.
module mwc_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        busy,
  output logic [63:0] remainder
);
  logic [63:0] rem;
  logic [63:0] quo;
  logic [63:0] dvs;
  logic [6:0]  count;
  logic [64:0] trial;

  assign trial = {rem, quo[63]} - {1'b0, dvs};
  assign busy = (count != 7'd0);
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 7'd0;
    end else if (start) begin
      count <= 7'd64;
    end else if (busy) begin
      count <= count - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= 64'd0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[62:0], 1'b0};
      if (!trial[64] || rem[63]) begin
        rem <= trial[63:0];
      end else begin
        rem <= {rem[62:0], quo[63]};
      end
    end
  end
endmodule

[sv/mwc_random_source_with_modn.sv]
// Multiply-with-carry random source. Two 16-bit MWC generators step once per
// 32-bit draw. One request is served at a time: in_stall is high from the
// cycle after an input transfer until the cycle after the result transfer.
// After the input transfer a request passes ST_SHIFT, then ST_DRAW, then
// ST_DONE, where out_valid rises, for r32, r16, r8, r1, a zero modulus, an
// unused opcode and the power-of-two shortcut of mod32p2; r64 and the
// power-of-two shortcut of mod64 add ST_DRAW2 for the low half. A rejection
// request stays in ST_SHIFT while it shifts the threshold up to the top bit
// (at most 63 shifts), makes at most 32 tries of ST_DRAW (and ST_DRAW2 for
// mod64) and ST_CHECK, then waits in ST_DIV for the shared one-bit-per-cycle
// divider. Seed writes through the APB port reload the generator words;
// write them only while idle.
module mwc_random_source_with_modn (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  opcode,
  input  logic [63:0] modulus,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] random_value,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  mwc_pkg::state_t state, state_next;
  logic [31:0] gen_z, gen_w, seed_w, seed_z;
  logic half_left; logic [31:0] half_buffer;
  logic [1:0] byte_left; logic [31:0] byte_buffer;
  logic [4:0] bit_left; logic [31:0] bit_buffer;
  logic [3:0] op;
  logic [63:0] m, thr, v, result;
  logic [6:0] width;
  logic [5:0] tries;
  logic [31:0] z_next, w_next, d32;
  logic wr;
  logic div_start, div_busy;
  logic [63:0] div_rem;
  logic [63:0] mm;
  logic [63:0] sub_v;
  logic [63:0] top;
  logic pow2;
  logic draw_en;
  logic two_draws;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == mwc_pkg::REG_SEED_Z) ? seed_z : seed_w;
  assign z_next = 32'd36969 * {16'd0, gen_z[15:0]} + {16'd0, gen_z[31:16]};
  assign w_next = 32'd18000 * {16'd0, gen_w[15:0]} + {16'd0, gen_w[31:16]};
  assign d32 = {z_next[15:0], 16'd0} + w_next;
  assign in_stall = (state != mwc_pkg::ST_IDLE);
  assign out_valid = (state == mwc_pkg::ST_DONE);
  assign random_value = result;
  assign top = 64'd1 << (width - 7'd1);
  assign div_start = (state == mwc_pkg::ST_CHECK) && ((v < thr) || tries == 6'd0);

  // Draw nothing for unused opcodes and for a zero modulus.
  assign draw_en = (op <= mwc_pkg::OP_MOD64) && !(op >= mwc_pkg::OP_MOD8 && m == 64'd0);
  // r64 and every nonzero mod64 request take a second draw for the low half.
  assign two_draws = (op == mwc_pkg::OP_R64) || (op == mwc_pkg::OP_MOD64 && m != 64'd0);

  // Mask modulus to the variant width.
  always_comb begin
    case (opcode) inside
      mwc_pkg::OP_MOD8:  mm = {56'd0, modulus[7:0]};
      mwc_pkg::OP_MOD16: mm = {48'd0, modulus[15:0]};
      mwc_pkg::OP_MOD32, mwc_pkg::OP_MOD32P2: mm = {32'd0, modulus[31:0]};
      default: mm = modulus;
    endcase
  end
  assign pow2 = ((mm & (mm - 64'd1)) == 64'd0);

  // Sub-word value for the current draw, from buffer or fresh draw.
  always_comb begin
    case (op) inside
      mwc_pkg::OP_R16, mwc_pkg::OP_MOD16:
        sub_v = half_left ? {48'd0, half_buffer[31:16]} : {48'd0, d32[15:0]};
      mwc_pkg::OP_R8, mwc_pkg::OP_MOD8:
        sub_v = (byte_left != 2'd0) ? {56'd0, byte_buffer[15:8]} : {56'd0, d32[7:0]};
      default:
        sub_v = (bit_left != 5'd0) ? {63'd0, bit_buffer[1]} : {63'd0, d32[0]};
    endcase
  end

  mwc_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(v), .divisor(m),
    .busy(div_busy), .remainder(div_rem)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      mwc_pkg::ST_IDLE: if (in_valid) state_next = mwc_pkg::ST_SHIFT;
      mwc_pkg::ST_SHIFT: begin
        if (thr < top && m != 64'd0 && width != 7'd0) state_next = mwc_pkg::ST_SHIFT;
        else state_next = mwc_pkg::ST_DRAW;
      end
      mwc_pkg::ST_DRAW: begin
        if (two_draws) state_next = mwc_pkg::ST_DRAW2;
        else if (width != 7'd0) state_next = mwc_pkg::ST_CHECK;
        else state_next = mwc_pkg::ST_DONE;
      end
      mwc_pkg::ST_DRAW2: begin
        if (width != 7'd0) state_next = mwc_pkg::ST_CHECK;
        else state_next = mwc_pkg::ST_DONE;
      end
      mwc_pkg::ST_CHECK: begin
        if (div_start) state_next = mwc_pkg::ST_DIV;
        else state_next = mwc_pkg::ST_DRAW;
      end
      mwc_pkg::ST_DIV: if (!div_busy) state_next = mwc_pkg::ST_DONE;
      mwc_pkg::ST_DONE: if (!out_stall) state_next = mwc_pkg::ST_IDLE;
      default: state_next = mwc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mwc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_z <= mwc_pkg::SEED_Z_RESET; gen_w <= mwc_pkg::SEED_W_RESET;
      seed_z <= mwc_pkg::SEED_Z_RESET; seed_w <= mwc_pkg::SEED_W_RESET;
      half_left <= 1'b0; half_buffer <= 32'd0;
      byte_left <= 2'd0; byte_buffer <= 32'd0;
      bit_left <= 5'd0; bit_buffer <= 32'd0;
    end else begin
      if (wr && paddr[2] == mwc_pkg::REG_SEED_W) begin
        seed_w <= pwdata; gen_w <= pwdata;
      end
      if (wr && paddr[2] == mwc_pkg::REG_SEED_Z) begin
        seed_z <= pwdata; gen_z <= pwdata;
      end
      case (state)
        mwc_pkg::ST_IDLE: begin
          op <= opcode;
          m <= mm;
          thr <= mm;
          tries <= 6'(mwc_pkg::MAX_TRIES - 1);
          result <= 64'd0;
          // Pick the rejection width, or drop to a plain draw.
          case (opcode)
            mwc_pkg::OP_MOD8:    width <= (mm != 64'd0) ? 7'd8 : 7'd0;
            mwc_pkg::OP_MOD16:   width <= (mm != 64'd0) ? 7'd16 : 7'd0;
            mwc_pkg::OP_MOD32:   width <= (mm != 64'd0) ? 7'd32 : 7'd0;
            mwc_pkg::OP_MOD32P2: width <= (mm != 64'd0 && !pow2) ? 7'd32 : 7'd0;
            mwc_pkg::OP_MOD64:   width <= (mm != 64'd0 && !pow2) ? 7'd64 : 7'd0;
            default: width <= 7'd0;
          endcase
        end
        mwc_pkg::ST_SHIFT: if (thr < top && m != 64'd0 && width != 7'd0) thr <= {thr[62:0], 1'b0};
        mwc_pkg::ST_DRAW: begin
          if (draw_en) begin
            case (op) inside
              mwc_pkg::OP_R16, mwc_pkg::OP_MOD16: begin
                half_left <= !half_left;
                if (half_left) half_buffer <= {16'd0, half_buffer[31:16]};
                else begin
                  half_buffer <= d32; gen_z <= z_next; gen_w <= w_next;
                end
                v <= sub_v; result <= sub_v;
              end
              mwc_pkg::OP_R8, mwc_pkg::OP_MOD8: begin
                if (byte_left != 2'd0) begin
                  byte_left <= byte_left - 2'd1;
                  byte_buffer <= {8'd0, byte_buffer[31:8]};
                end else begin
                  byte_left <= 2'd3; byte_buffer <= d32;
                  gen_z <= z_next; gen_w <= w_next;
                end
                v <= sub_v; result <= sub_v;
              end
              mwc_pkg::OP_R1: begin
                if (bit_left != 5'd0) begin
                  bit_left <= bit_left - 5'd1;
                  bit_buffer <= {1'b0, bit_buffer[31:1]};
                end else begin
                  bit_left <= 5'd31; bit_buffer <= d32;
                  gen_z <= z_next; gen_w <= w_next;
                end
                result <= sub_v;
              end
              default: begin
                gen_z <= z_next; gen_w <= w_next;
                v <= {32'd0, d32};
                if ((op == mwc_pkg::OP_MOD32P2 || op == mwc_pkg::OP_MOD64) && width == 7'd0)
                  result <= {32'd0, d32} & (m - 64'd1);
                else
                  result <= {32'd0, d32};
              end
            endcase
          end
        end
        mwc_pkg::ST_DRAW2: begin
          gen_z <= z_next; gen_w <= w_next;
          v <= {v[31:0], d32};
          if (op == mwc_pkg::OP_MOD64 && width == 7'd0)
            result <= {v[31:0], d32} & (m - 64'd1);
          else
            result <= {v[31:0], d32};
        end
        mwc_pkg::ST_CHECK: tries <= tries - 6'd1;
        mwc_pkg::ST_DIV: if (!div_busy && !div_start) result <= div_rem;
        default: ;
      endcase
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(random_value)) else $error("result changed");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("accepting while result pending");
  a_div: assert property (@(posedge clk) disable iff (rst)
    div_start |=> state == mwc_pkg::ST_DIV) else $error("divider start lost");
endmodule
